// ===== rtl/dst_rule_transition_time_unit_defines.svh =====
// assertion macros shared by the rule transition time block
`ifndef DST_RULE_TRANSITION_TIME_UNIT_DEFINES_SVH
`define DST_RULE_TRANSITION_TIME_UNIT_DEFINES_SVH

// pre implies post in the same cycle, checked on clock, muted in reset
`define DSTR_ASSERT_IMPL(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("dstr check failed");

// pre implies post after a delay given by the argument n
`define DSTR_ASSERT_DELAY(label, pre, n, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> ##n (post)) \
      else $error("dstr latency check failed");

`endif

// ===== rtl/dstr_pkg.sv =====
// types, constants and calendar tables for the rule transition time block
package dstr_pkg;

   localparam int unsigned SecsPerDay = 24 * 60 * 60;
   localparam logic [15:0] LongMonthMask = 16'b0001010110101010;
   localparam logic [5:0]  MaxWeek = 6'd52;

   localparam logic [1:0] KIND_PLAIN  = 2'd0;
   localparam logic [1:0] KIND_JULIAN = 2'd1;
   localparam logic [1:0] KIND_MONTH  = 2'd2;

   // rule with month and week already clamped for month rules
   typedef struct packed {
      logic [1:0]         kind;
      logic [3:0]         month;
      logic [5:0]         week;
      logic [8:0]         day;
      logic signed [20:0] tod;
   } rule_type;

   // year terms needed by the weekday formula
   typedef struct packed {
      logic       leap;
      logic       neg;
      logic [7:0] q100;
      logic [6:0] rem;
   } ycal_type;

   // (26 * march_based_month - 2) / 10, indexed by the clamped month
   function automatic logic [4:0] month_term(input logic [3:0] m);
      logic [4:0] t;
      case (m)
         4'd1:    t = 5'd28;
         4'd2:    t = 5'd31;
         4'd3:    t = 5'd2;
         4'd4:    t = 5'd5;
         4'd5:    t = 5'd7;
         4'd6:    t = 5'd10;
         4'd7:    t = 5'd12;
         4'd8:    t = 5'd15;
         4'd9:    t = 5'd18;
         4'd10:   t = 5'd20;
         4'd11:   t = 5'd23;
         4'd12:   t = 5'd25;
         default: t = 5'd0;
      endcase
      return t;
   endfunction

   function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
      logic [4:0] d;
      if (m == 4'd2) begin
         d = leap ? 5'd29 : 5'd28;
      end else begin
         d = 5'd30 + {4'd0, LongMonthMask[m]};
      end
      return d;
   endfunction

   // days before the first of the month in a common year
   function automatic logic [8:0] days_before(input logic [3:0] m);
      logic [8:0] d;
      case (m)
         4'd1:    d = 9'd0;
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

// ===== rtl/dstr_year_div.sv =====
// two stages: year divided by 100 through a reciprocal multiply, leap flag
module dstr_year_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  dstr_pkg::rule_type in_rule,
   input  logic [13:0]        in_year,
   output logic               out_valid,
   output dstr_pkg::rule_type out_rule,
   output dstr_pkg::ycal_type out_ycal
);
   import dstr_pkg::*;

   localparam logic [12:0] Recip100 = 13'd5243;

   logic        s1_valid_ff;
   rule_type    s1_rule_ff;
   logic        s1_neg_ff;
   logic [13:0] s1_ay_ff;
   logic [13:0] s1_year_ff;
   logic [26:0] s1_pa_ff;
   logic [26:0] s1_py_ff;

   logic        early;
   logic        neg_in;
   logic [13:0] ay_in;

   logic        s2_valid_ff;
   rule_type    s2_rule_ff;
   ycal_type    s2_ycal_ff;

   logic [7:0]  q100a;
   logic [7:0]  q100y;
   logic [13:0] rema;
   logic [13:0] remy;
   ycal_type    ycal_in;

   // january and february belong to the previous year
   assign early  = (in_rule.month <= 4'd2);
   assign neg_in = early && (in_year == 14'd0);
   assign ay_in  = neg_in ? 14'd0 : (in_year - {13'd0, early});

   assign q100a = s1_pa_ff[26:19];
   assign q100y = s1_py_ff[26:19];
   assign rema  = s1_ay_ff - 14'({6'd0, q100a} * 14'd100);
   assign remy  = s1_year_ff - 14'({6'd0, q100y} * 14'd100);

   always_comb begin
      ycal_in.neg  = s1_neg_ff;
      ycal_in.q100 = q100a;
      ycal_in.rem  = rema[6:0];
      ycal_in.leap = (s1_year_ff[1:0] == 2'd0) &&
                     ((remy != 14'd0) || (q100y[1:0] == 2'd0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
      s1_rule_ff <= in_rule;
      s1_neg_ff  <= neg_in;
      s1_ay_ff   <= ay_in;
      s1_year_ff <= in_year;
      s1_pa_ff   <= ay_in * Recip100;
      s1_py_ff   <= in_year * Recip100;
      s2_rule_ff <= s1_rule_ff;
      s2_ycal_ff <= ycal_in;
   end

   assign out_valid = s2_valid_ff;
   assign out_rule  = s2_rule_ff;
   assign out_ycal  = s2_ycal_ff;

endmodule

// ===== rtl/dstr_weekday.sv =====
// two stages: weekday of the first of the month, first matching weekday
module dstr_weekday (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  dstr_pkg::rule_type in_rule,
   input  dstr_pkg::ycal_type in_ycal,
   output logic               out_valid,
   output dstr_pkg::rule_type out_rule,
   output logic               out_leap,
   output logic [8:0]         out_first
);
   import dstr_pkg::*;

   localparam logic [11:0] SumBias = 12'd329;
   localparam logic [10:0] Recip7 = 11'd1171;

   logic        s3_valid_ff;
   rule_type    s3_rule_ff;
   logic        s3_leap_ff;
   logic [9:0]  s3_x_ff;
   logic [20:0] s3_prod_ff;

   logic [11:0] rem_term;
   logic [11:0] remq_term;
   logic [11:0] sum_in;

   logic        s4_valid_ff;
   rule_type    s4_rule_ff;
   logic        s4_leap_ff;
   logic [8:0]  s4_first_ff;

   logic [6:0]  q7;
   logic [9:0]  r10;
   logic [2:0]  dow;
   logic [9:0]  dd;
   logic [9:0]  first_in;

   // a year of minus one leaves a remainder of minus one and nothing else
   assign rem_term  = in_ycal.neg ? 12'hFFF : {5'd0, in_ycal.rem};
   assign remq_term = in_ycal.neg ? 12'd0 : {7'd0, in_ycal.rem[6:2]};
   // bias by a multiple of seven keeps the sum positive
   assign sum_in = {7'd0, month_term(in_rule.month)} + 12'd1 + rem_term + remq_term
                 + {6'd0, in_ycal.q100[7:2]} - {3'd0, in_ycal.q100, 1'b0} + SumBias;

   assign q7  = s3_prod_ff[19:13];
   assign r10 = s3_x_ff - 10'({3'd0, q7} * 10'd7);
   assign dow = (r10 >= 10'd7) ? 3'(r10 - 10'd7) : r10[2:0];
   assign dd  = {1'b0, s3_rule_ff.day} - {7'd0, dow};
   assign first_in = dd[9] ? (dd + 10'd7) : dd;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= in_valid;
         s4_valid_ff <= s3_valid_ff;
      end
      s3_rule_ff  <= in_rule;
      s3_leap_ff  <= in_ycal.leap;
      s3_x_ff     <= sum_in[9:0];
      s3_prod_ff  <= sum_in[9:0] * Recip7;
      s4_rule_ff  <= s3_rule_ff;
      s4_leap_ff  <= s3_leap_ff;
      s4_first_ff <= first_in[8:0];
   end

   assign out_valid = s4_valid_ff;
   assign out_rule  = s4_rule_ff;
   assign out_leap  = s4_leap_ff;
   assign out_first = s4_first_ff;

endmodule

// ===== rtl/dstr_day_place.sv =====
// one stage: week stepping, days of earlier months, julian and plain days
module dstr_day_place (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  dstr_pkg::rule_type in_rule,
   input  logic               in_leap,
   input  logic [8:0]         in_first,
   output logic               out_valid,
   output logic signed [20:0] out_tod,
   output logic [9:0]         out_day
);
   import dstr_pkg::*;

   logic               s5_valid_ff;
   logic signed [20:0] s5_tod_ff;
   logic [9:0]         s5_day_ff;

   logic [4:0]         mdays;
   logic signed [10:0] room;
   logic [2:0]         steps;
   logic [5:0]         wm1;
   logic [2:0]         take;
   logic [9:0]         month_day;
   logic [8:0]         jn;
   logic [9:0]         julian_day;
   logic [9:0]         day_in;

   assign mdays = month_days(in_rule.month, in_leap);
   // whole weeks that still fit in the month
   assign room  = $signed({6'd0, mdays}) - 11'sd1 - $signed({2'd0, in_first});
   assign steps = {2'd0, room >= 11'sd7} + {2'd0, room >= 11'sd14}
                + {2'd0, room >= 11'sd21} + {2'd0, room >= 11'sd28};
   assign wm1   = in_rule.week - 6'd1;
   assign take  = (wm1 < {3'd0, steps}) ? wm1[2:0] : steps;
   assign month_day = {1'b0, in_first} + ({7'd0, take} * 10'd7)
                    + {1'b0, days_before(in_rule.month)}
                    + {9'd0, in_leap && (in_rule.month > 4'd2)};

   // julian zero counts as julian one
   assign jn = (in_rule.day == 9'd0) ? 9'd1 : in_rule.day;
   assign julian_day = {1'b0, jn} - 10'd1 + {9'd0, in_leap && (jn >= 9'd60)};

   always_comb begin
      case (in_rule.kind)
         KIND_MONTH:  day_in = month_day;
         KIND_JULIAN: day_in = julian_day;
         default:     day_in = {1'b0, in_rule.day};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= in_valid;
      end
      s5_tod_ff <= in_rule.tod;
      s5_day_ff <= day_in;
   end

   assign out_valid = s5_valid_ff;
   assign out_tod   = s5_tod_ff;
   assign out_day   = s5_day_ff;

endmodule

// ===== rtl/dst_rule_transition_time_unit.sv =====
// top level: daylight-saving rule transition instant in seconds into the year
//
// one rule and a year go in on the req_ ports, qualified by start; busy
// stays low, so a beat is taken at every edge where start is high and a
// new rule may follow in every cycle
// rsp_seconds_into_year appears with rsp_strobe for exactly one cycle,
// once the rule has passed through all six register stages, in order
// throughput is one rule per cycle through six register stages:
//   two for the year split by 100 (reciprocal multiply) and leap flag,
//   two for the weekday of the first of the month (mod 7 multiply),
//   one for week stepping and month offsets, one for day * 86400 + time
// the receiver cannot hold results off; each result is there one cycle
// reset clears every stage valid bit, so nothing comes out after reset
// until new rules are taken; no clearing pass is needed
`include "dst_rule_transition_time_unit_defines.svh"

module dst_rule_transition_time_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_rule_kind,
   input  logic [3:0]         req_rule_month,
   input  logic [5:0]         req_rule_week,
   input  logic [8:0]         req_rule_day,
   input  logic signed [20:0] req_rule_time,
   input  logic [13:0]        req_calendar_year,
   output logic               rsp_strobe,
   output logic signed [27:0] rsp_seconds_into_year
);
   import dstr_pkg::*;

   localparam logic [16:0] DaySecs = 17'(SecsPerDay);

   rule_type           rule_in;
   logic               accept;

   logic               yd_valid;
   rule_type           yd_rule;
   ycal_type           yd_ycal;

   logic               wd_valid;
   rule_type           wd_rule;
   logic               wd_leap;
   logic [8:0]         wd_first;

   logic               dp_valid;
   logic signed [20:0] dp_tod;
   logic [9:0]         dp_day;

   logic               rsp_strobe_ff;
   logic signed [27:0] rsp_seconds_ff;
   logic signed [27:0] seconds_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_comb begin
      rule_in.kind  = req_rule_kind;
      rule_in.month = (req_rule_month == 4'd0) ? 4'd1 :
                      (req_rule_month > 4'd12) ? 4'd12 : req_rule_month;
      rule_in.week  = (req_rule_week == 6'd0) ? 6'd1 :
                      (req_rule_week > MaxWeek) ? MaxWeek : req_rule_week;
      rule_in.day   = req_rule_day;
      rule_in.tod   = req_rule_time;
   end

   dstr_year_div u_year_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_rule   (rule_in),
      .in_year   (req_calendar_year),
      .out_valid (yd_valid),
      .out_rule  (yd_rule),
      .out_ycal  (yd_ycal)
   );

   dstr_weekday u_weekday (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (yd_valid),
      .in_rule   (yd_rule),
      .in_ycal   (yd_ycal),
      .out_valid (wd_valid),
      .out_rule  (wd_rule),
      .out_leap  (wd_leap),
      .out_first (wd_first)
   );

   dstr_day_place u_day_place (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (wd_valid),
      .in_rule   (wd_rule),
      .in_leap   (wd_leap),
      .in_first  (wd_first),
      .out_valid (dp_valid),
      .out_tod   (dp_tod),
      .out_day   (dp_day)
   );

   assign seconds_in = {{7{dp_tod[20]}}, dp_tod} + $signed({1'b0, 27'(dp_day * DaySecs)});

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= dp_valid;
      end
      rsp_seconds_ff <= seconds_in;
   end

   assign rsp_strobe            = rsp_strobe_ff;
   assign rsp_seconds_into_year = rsp_seconds_ff;

   // every beat taken comes out as a result
   `DSTR_ASSERT_DELAY(a_latency, accept, 6, rsp_strobe)
   // no result without a beat taken before it
   `DSTR_ASSERT_IMPL(a_no_phantom, rsp_strobe, $past(accept, 6))
   // a negative instant needs a negative time of day
   `DSTR_ASSERT_IMPL(a_sign, rsp_strobe && rsp_seconds_into_year[27],
      $past(req_rule_time[20], 6))

endmodule
